FILE: design/hrhp_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the HTTP request header parser.
// Holds the parse phase encoding, the per-line state record and the result record.
// No dependencies.
package hrhp_pkg;

  // Parse phase of the current line
  typedef enum logic [3:0] {
    PH_METHOD,
    PH_SEP,
    PH_PATH,
    PH_QUERY,
    PH_MARK,
    PH_VERSION,
    PH_NAME,
    PH_COLON_SP,
    PH_VALUE,
    PH_BAD_METHOD,
    PH_BAD_MARK
  } phase_t;

  // Event codes carried in the result kind
  localparam logic [3:0] EV_METHOD     = 4'd0;
  localparam logic [3:0] EV_PATH       = 4'd1;
  localparam logic [3:0] EV_QUERY      = 4'd2;
  localparam logic [3:0] EV_VERSION    = 4'd3;
  localparam logic [3:0] EV_REQ_END    = 4'd4;
  localparam logic [3:0] EV_NAME       = 4'd5;
  localparam logic [3:0] EV_VALUE      = 4'd6;
  localparam logic [3:0] EV_HDR_END    = 4'd7;
  localparam logic [3:0] EV_SUCCESS    = 4'd8;
  localparam logic [3:0] EV_ERROR      = 4'd9;

  // Error codes carried in the value of an error event
  localparam logic [7:0] ERR_NO_LINE_END = 8'd0;
  localparam logic [7:0] ERR_NUL         = 8'd1;
  localparam logic [7:0] ERR_NO_METHOD   = 8'd2;
  localparam logic [7:0] ERR_NO_SPACE    = 8'd3;
  localparam logic [7:0] ERR_NO_MARKER   = 8'd4;
  localparam logic [7:0] ERR_NO_COLON    = 8'd5;

  // Special characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam int unsigned METHOD_COUNT = 6;
  localparam int unsigned MARKER_LEN   = 5;

  // Method spellings: GET, HEAD, POST, PUT, OPTIONS, DELETE (zero padded)
  localparam logic [7:0] METHOD_TEXT [METHOD_COUNT][8] = '{
    '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h48, 8'h45, 8'h41, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h55, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4F, 8'h50, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h53, 8'h00},
    '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h00, 8'h00}
  };
  localparam logic [3:0] METHOD_LEN [METHOD_COUNT] = '{
    4'd3, 4'd4, 4'd4, 4'd3, 4'd7, 4'd6
  };

  // Version marker "HTTP/" (zero padded)
  localparam logic [7:0] MARKER_TEXT [8] = '{
    8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h00, 8'h00, 8'h00
  };

  // Per-line parse state
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  mpos;
    logic [5:0]  cands;
    logic        held;
    logic [1:0]  len;
    logic        nul;
  } line_t;

  // One result transaction
  typedef struct packed {
    logic [3:0] event_res;
    logic [7:0] value;
    logic       last_of_run;
  } res_t;

  localparam int unsigned MAX_RESULTS = 3;

endpackage

FILE: design/http_request_header_parser_unit.sv
`timescale 1ns / 1ps
// HTTP request header parser: request line and header line tokeniser.
// Top level; depends on hrhp_pkg and hrhp_res_queue.
//
// Usage:
//   Raw request bytes enter on the slave stream (s_tdata, s_tlast marks the
//   final byte of a message). Each byte causes zero to three result
//   transactions on the master stream: m_tuser is the event kind, m_tdata
//   the byte, method code or error code, m_tlast marks the last result of
//   that input byte.
//   A byte is taken into an input register, parsed there combinationally and
//   its results are written to a four-entry result queue. m_tvalid rises once
//   the results have passed the input register and been written into the
//   queue, where the first result transaction waits for m_tready.
//   Throughput: one byte per cycle while each byte yields at most one result
//   and m_tready stays high; a byte with more results holds the master port
//   once per result, which sets the sustained rate (one result per cycle out of the queue).
//   When the receiver stalls, the queue fills and s_tready drops once fewer
//   than three entries are free; nothing is lost or repeated.
//   Reset (rst, synchronous) empties the queue and the input register and
//   returns the parser to the method phase; the same parse state is restored
//   after every byte that carries s_tlast.
//   VERSION_BYTES_MAX bounds the version bytes streamed per request line.
module http_request_header_parser_unit #(
  parameter int unsigned VERSION_BYTES_MAX = 7
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // message_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] value
  output logic [3:0] m_tuser,   // [3:0] event_res
  output logic       m_tlast    // last_of_run
);

  localparam int unsigned VW = $clog2(VERSION_BYTES_MAX + 1);

  // Input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       consume;
  logic       room;

  // Parse state
  hrhp_pkg::line_t line;
  hrhp_pkg::line_t line_next;
  logic [VW-1:0]   vcount;
  logic [VW-1:0]   vcount_next;
  logic            finished;
  logic            finished_next;

  // Results of the current byte
  hrhp_pkg::res_t  push_data [hrhp_pkg::MAX_RESULTS];
  logic [1:0]      push_n;
  hrhp_pkg::res_t  out_data;

  localparam hrhp_pkg::line_t LINE_RESET = '{
    phase: hrhp_pkg::PH_METHOD,
    mpos:  3'd0,
    cands: 6'h3F,
    held:  1'b0,
    len:   2'd0,
    nul:   1'b0
  };

  assign consume  = in_valid && room;
  assign s_tready = !in_valid || consume;

  // Load the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Parse one content byte of a line
  function automatic void feed(
    input  hrhp_pkg::line_t si,
    input  logic [VW-1:0]   vi,
    input  logic [7:0]      b,
    output hrhp_pkg::line_t so,
    output logic [VW-1:0]   vo,
    output logic            ev_v,
    output hrhp_pkg::res_t  ev
  );
    logic [5:0] keep;
    logic       found;
    logic [2:0] mcode;
    so    = si;
    vo    = vi;
    ev_v  = 1'b0;
    ev    = '0;
    keep  = '0;
    found = 1'b0;
    mcode = '0;
    if (si.nul) begin
      // drop the rest of a line after a NUL
    end else if (b == hrhp_pkg::CH_NUL) begin
      so.nul = 1'b1;
    end else begin
      case (si.phase)
        hrhp_pkg::PH_METHOD: begin
          for (int i = 0; i < hrhp_pkg::METHOD_COUNT; i++) begin
            if (si.cands[i] && ({1'b0, si.mpos} < hrhp_pkg::METHOD_LEN[i]) &&
                (hrhp_pkg::METHOD_TEXT[i][si.mpos] == b)) begin
              keep[i] = 1'b1;
            end
          end
          so.cands = keep;
          // lowest completed method wins
          for (int i = hrhp_pkg::METHOD_COUNT - 1; i >= 0; i--) begin
            if (keep[i] && (({1'b0, si.mpos} + 4'd1) == hrhp_pkg::METHOD_LEN[i])) begin
              found = 1'b1;
              mcode = 3'(i);
            end
          end
          if (keep == '0) begin
            so.phase = hrhp_pkg::PH_BAD_METHOD;
          end else if (found) begin
            so.phase = hrhp_pkg::PH_SEP;
            so.mpos  = 3'd0;
            ev_v     = 1'b1;
            ev       = '{hrhp_pkg::EV_METHOD, {5'd0, mcode}, 1'b0};
          end else begin
            so.mpos = si.mpos + 3'd1;
          end
        end
        hrhp_pkg::PH_SEP: begin
          so.phase = hrhp_pkg::PH_PATH;
        end
        hrhp_pkg::PH_PATH: begin
          if (b == hrhp_pkg::CH_SPACE) begin
            so.phase = hrhp_pkg::PH_MARK;
            so.mpos  = 3'd0;
          end else if (b == hrhp_pkg::CH_QMARK) begin
            so.phase = hrhp_pkg::PH_QUERY;
          end else begin
            ev_v = 1'b1;
            ev   = '{hrhp_pkg::EV_PATH, b, 1'b0};
          end
        end
        hrhp_pkg::PH_QUERY: begin
          if (b == hrhp_pkg::CH_SPACE) begin
            so.phase = hrhp_pkg::PH_MARK;
            so.mpos  = 3'd0;
          end else begin
            ev_v = 1'b1;
            ev   = '{hrhp_pkg::EV_QUERY, b, 1'b0};
          end
        end
        hrhp_pkg::PH_MARK: begin
          if ((si.mpos < 3'(hrhp_pkg::MARKER_LEN)) &&
              (hrhp_pkg::MARKER_TEXT[si.mpos] == b)) begin
            if (si.mpos == 3'(hrhp_pkg::MARKER_LEN - 1)) begin
              so.phase = hrhp_pkg::PH_VERSION;
              so.mpos  = 3'd0;
              vo       = '0;
            end else begin
              so.mpos = si.mpos + 3'd1;
            end
          end else begin
            so.phase = hrhp_pkg::PH_BAD_MARK;
          end
        end
        hrhp_pkg::PH_VERSION: begin
          if (vi < VW'(VERSION_BYTES_MAX)) begin
            vo   = vi + VW'(1);
            ev_v = 1'b1;
            ev   = '{hrhp_pkg::EV_VERSION, b, 1'b0};
          end
        end
        hrhp_pkg::PH_NAME: begin
          if (b == hrhp_pkg::CH_COLON) begin
            so.phase = hrhp_pkg::PH_COLON_SP;
          end else begin
            ev_v = 1'b1;
            ev   = '{hrhp_pkg::EV_NAME, b, 1'b0};
          end
        end
        hrhp_pkg::PH_COLON_SP: begin
          so.phase = hrhp_pkg::PH_VALUE;
          if (b != hrhp_pkg::CH_SPACE) begin
            ev_v = 1'b1;
            ev   = '{hrhp_pkg::EV_VALUE, b, 1'b0};
          end
        end
        hrhp_pkg::PH_VALUE: begin
          ev_v = 1'b1;
          ev   = '{hrhp_pkg::EV_VALUE, b, 1'b0};
        end
        default: begin
        end
      endcase
    end
  endfunction

  // Next state and results of the registered byte
  always_comb begin
    hrhp_pkg::line_t ls;
    hrhp_pkg::line_t la;
    hrhp_pkg::line_t lb;
    logic [VW-1:0]   vc;
    logic [VW-1:0]   va;
    logic [VW-1:0]   vb;
    logic            fin;
    logic [2:0]      rv;
    hrhp_pkg::res_t  r [hrhp_pkg::MAX_RESULTS];
    logic [1:0]      idx;

    ls   = line;
    vc   = vcount;
    fin  = finished;
    rv   = '0;
    r[0] = '0;
    r[1] = '0;
    r[2] = '0;
    la   = line;
    lb   = line;
    va   = vcount;
    vb   = vcount;
    idx  = '0;
    for (int k = 0; k < hrhp_pkg::MAX_RESULTS; k++) begin
      push_data[k] = '0;
    end

    if (!fin) begin
      if (in_byte == hrhp_pkg::CH_LF) begin
        // close the line
        rv[0] = 1'b1;
        if (ls.len < 2'd2) begin
          fin  = 1'b1;
          r[0] = '{hrhp_pkg::EV_SUCCESS, 8'd0, 1'b0};
        end else if (ls.nul) begin
          fin  = 1'b1;
          r[0] = '{hrhp_pkg::EV_ERROR, hrhp_pkg::ERR_NUL, 1'b0};
        end else begin
          case (ls.phase)
            hrhp_pkg::PH_METHOD, hrhp_pkg::PH_BAD_METHOD: begin
              fin  = 1'b1;
              r[0] = '{hrhp_pkg::EV_ERROR, hrhp_pkg::ERR_NO_METHOD, 1'b0};
            end
            hrhp_pkg::PH_SEP, hrhp_pkg::PH_PATH, hrhp_pkg::PH_QUERY: begin
              fin  = 1'b1;
              r[0] = '{hrhp_pkg::EV_ERROR, hrhp_pkg::ERR_NO_SPACE, 1'b0};
            end
            hrhp_pkg::PH_MARK, hrhp_pkg::PH_BAD_MARK: begin
              fin  = 1'b1;
              r[0] = '{hrhp_pkg::EV_ERROR, hrhp_pkg::ERR_NO_MARKER, 1'b0};
            end
            hrhp_pkg::PH_VERSION: begin
              ls.phase = hrhp_pkg::PH_NAME;
              r[0]     = '{hrhp_pkg::EV_REQ_END, 8'd0, 1'b0};
            end
            hrhp_pkg::PH_COLON_SP, hrhp_pkg::PH_VALUE: begin
              ls.phase = hrhp_pkg::PH_NAME;
              r[0]     = '{hrhp_pkg::EV_HDR_END, 8'd0, 1'b0};
            end
            default: begin
              fin  = 1'b1;
              r[0] = '{hrhp_pkg::EV_ERROR, hrhp_pkg::ERR_NO_COLON, 1'b0};
            end
          endcase
        end
        ls.len  = 2'd0;
        ls.nul  = 1'b0;
        ls.mpos = 3'd0;
        ls.held = 1'b0;
        vc      = '0;
      end else begin
        if (ls.len < 2'd2) begin
          ls.len = ls.len + 2'd1;
        end
        // release a held CR as content
        if (ls.held) begin
          ls.held = 1'b0;
          feed(ls, vc, hrhp_pkg::CH_CR, la, va, rv[0], r[0]);
          ls = la;
          vc = va;
        end
        if ((in_byte == hrhp_pkg::CH_CR) && !in_last) begin
          ls.held = 1'b1;
        end else begin
          feed(ls, vc, in_byte, lb, vb, rv[1], r[1]);
          ls = lb;
          vc = vb;
        end
      end
      if (in_last && !fin) begin
        fin   = 1'b1;
        rv[2] = 1'b1;
        r[2]  = '{hrhp_pkg::EV_ERROR, hrhp_pkg::ERR_NO_LINE_END, 1'b0};
      end
    end

    // pack results in order and mark the last one
    for (int k = 0; k < hrhp_pkg::MAX_RESULTS; k++) begin
      if (rv[k]) begin
        push_data[idx] = r[k];
        idx            = idx + 2'd1;
      end
    end
    if (idx != 2'd0) begin
      push_data[idx - 2'd1].last_of_run = 1'b1;
    end
    push_n = consume ? idx : 2'd0;

    if (in_last) begin
      ls  = LINE_RESET;
      vc  = '0;
      fin = 1'b0;
    end
    line_next     = ls;
    vcount_next   = vc;
    finished_next = fin;
  end

  // Advance parse state on each consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      line     <= LINE_RESET;
      vcount   <= '0;
      finished <= 1'b0;
    end else if (consume) begin
      line     <= line_next;
      vcount   <= vcount_next;
      finished <= finished_next;
    end
  end

  hrhp_res_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_data (push_data),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = out_data.value;
  assign m_tuser = out_data.event_res;
  assign m_tlast = out_data.last_of_run;

  // A message end always restores the method phase
  assert property (@(posedge clk) disable iff (rst)
    (consume && in_last) |=> (line.phase == hrhp_pkg::PH_METHOD) && !finished)
    else $error("parser state not restored after message end");

  // Once finished, a byte yields no result
  assert property (@(posedge clk) disable iff (rst)
    (consume && finished) |-> (push_n == 2'd0))
    else $error("result produced after success or error");

  // A message end on a live parse always reports an outcome
  assert property (@(posedge clk) disable iff (rst)
    (consume && !finished && in_last) |-> (push_n != 2'd0))
    else $error("message ended without an outcome");

endmodule

FILE: design/hrhp_res_queue.sv
`timescale 1ns / 1ps
// Result queue of the HTTP request header parser: four entries, up to three
// written per cycle, one read per cycle on a stream master while out_ready is high.
// Depends on hrhp_pkg.
module hrhp_res_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_n,
  input  hrhp_pkg::res_t  push_data [hrhp_pkg::MAX_RESULTS],
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output hrhp_pkg::res_t  out_data
);

  hrhp_pkg::res_t entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign out_data  = entries[rd_ptr];
  // Room for a full run of results without counting this cycle's pop
  assign room      = (count <= 3'd1);

  assign count_next = count + {1'b0, push_n} - {2'b00, pop};

  // Hold control pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

  // Write the pushed results in order
  always_ff @(posedge clk) begin
    for (int k = 0; k < hrhp_pkg::MAX_RESULTS; k++) begin
      if (2'(k) < push_n) begin
        entries[wr_ptr + 2'(k)] <= push_data[k];
      end
    end
  end

endmodule
